@@ rtl/core/plsr_pkg.sv @@
package plsr_pkg;

	localparam int KIND_W    = 3;
	localparam int POSN_W    = 5;
	localparam int DATA_W    = 32;
	localparam int CNT_OUT_W = 5;
	localparam int STATUS_W  = 2;

	// Wide enough for any slot index or fill level up to the largest supported depth.
	localparam int POS_W = 9;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_HEAD = 3'd0,
		KIND_PUSH_TAIL = 3'd1,
		KIND_INSERT_AT = 3'd2,
		KIND_POP_HEAD  = 3'd3,
		KIND_POP_TAIL  = 3'd4,
		KIND_POP_AT    = 3'd5,
		KIND_READ_AT   = 3'd6
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic [POS_W-1:0]          pos;
		logic signed [DATA_W-1:0]  value;
	} cell_cmd_t;

endpackage

@@ rtl/core/plsr_op_if.sv @@
interface plsr_op_if;
	logic                                 valid;
	logic                                 ready;
	logic [plsr_pkg::KIND_W-1:0]          kind;
	logic [plsr_pkg::POSN_W-1:0]          position;
	logic signed [plsr_pkg::DATA_W-1:0]   value;

	modport source (output valid, kind, position, value, input ready);
	modport sink (input valid, kind, position, value, output ready);
endinterface

@@ rtl/core/plsr_res_if.sv @@
interface plsr_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [plsr_pkg::DATA_W-1:0]   read_value;
	logic [plsr_pkg::STATUS_W-1:0]        status;
	logic [plsr_pkg::CNT_OUT_W-1:0]       entry_count;

	modport source (output valid, read_value, status, entry_count, input ready);
	modport sink (input valid, read_value, status, entry_count, output ready);
endinterface

@@ rtl/core/plsr_cell.sv @@
module plsr_cell #(
	parameter int INDEX = 0
) (
	input  logic                                clk,
	input  plsr_pkg::cell_cmd_t                 cmd,
	input  logic signed [plsr_pkg::DATA_W-1:0]  left,
	input  logic signed [plsr_pkg::DATA_W-1:0]  right,
	output logic signed [plsr_pkg::DATA_W-1:0]  data
);

	localparam logic [plsr_pkg::POS_W-1:0] IDX = plsr_pkg::POS_W'(INDEX);

	logic signed [plsr_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			plsr_pkg::OP_INS: begin
				if (IDX == cmd.pos) begin
					data_q <= cmd.value;
				end else if (IDX > cmd.pos) begin
					data_q <= left;
				end
			end
			plsr_pkg::OP_DEL: begin
				if (IDX >= cmd.pos) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

@@ rtl/core/plsr_collect.sv @@
module plsr_collect #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                load,
	input  logic                                rd_en,
	input  logic [plsr_pkg::POS_W-1:0]          pos,
	input  logic signed [plsr_pkg::DATA_W-1:0]  cell_data [DEPTH],
	output logic signed [plsr_pkg::DATA_W-1:0]  value
);

	localparam int GROUP  = 16;
	localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

	logic [plsr_pkg::DATA_W-1:0] grp_d  [NGROUP];
	logic [plsr_pkg::DATA_W-1:0] grp_s1 [NGROUP];

	// Each cell drives the bus only when it is the addressed slot of a read.
	for (genvar g = 0; g < NGROUP; g++) begin : g_grp
		always_comb begin
			grp_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < DEPTH) begin
					if (rd_en && pos == plsr_pkg::POS_W'(g * GROUP + k)) begin
						grp_d[g] = grp_d[g] | cell_data[g * GROUP + k];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (load) begin
				grp_s1[g] <= grp_d[g];
			end
		end
	end

	always_comb begin
		logic [plsr_pkg::DATA_W-1:0] acc;
		acc = '0;
		for (int g = 0; g < NGROUP; g++) begin
			acc = acc | grp_s1[g];
		end
		value = acc;
	end

endmodule

@@ rtl/core/positional_list_store.sv @@
// Channel   Dir  Payload                              Transfer when
// op        in   kind, position, value                op.valid && op.ready
// res       out  read_value, status, entry_count      res.valid && res.ready
//
// The row of cells shifts in the same cycle that an operation is accepted.
// Its result passes through the read-out register and then the output register, which drives res.
// A new operation is taken every cycle while the result stage drains.
// Reset empties the list at once; stored values are left as they are.
// A stalled result holds the output register, and one more operation may wait behind it.
module positional_list_store #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	plsr_op_if.sink          op,
	plsr_res_if.source       res
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [plsr_pkg::POS_W-1:0] DEPTH_X = plsr_pkg::POS_W'(DEPTH);

	logic [CW-1:0]                       cnt_q;
	logic [CW-1:0]                       cnt_d;
	logic [plsr_pkg::POS_W-1:0]          cnt_x;
	logic [plsr_pkg::POS_W-1:0]          pos_x;
	logic                                full;
	logic                                empty;
	logic                                rd_en;
	plsr_pkg::status_t                   status_d;
	plsr_pkg::cell_op_t                  op_d;
	logic [plsr_pkg::POS_W-1:0]          at_d;
	plsr_pkg::cell_cmd_t                 cmd;
	logic                                accept;
	logic                                adv_out;

	logic                                v_s1;
	logic                                rd_s1;
	plsr_pkg::status_t                   status_s1;
	logic [plsr_pkg::CNT_OUT_W-1:0]      count_s1;

	logic                                v_q;
	logic signed [plsr_pkg::DATA_W-1:0]  value_q;
	plsr_pkg::status_t                   status_q;
	logic [plsr_pkg::CNT_OUT_W-1:0]      count_q;

	logic signed [plsr_pkg::DATA_W-1:0]  cell_data [DEPTH];
	logic signed [plsr_pkg::DATA_W-1:0]  rd_value;

	assign cnt_x = plsr_pkg::POS_W'(cnt_q);
	assign pos_x = plsr_pkg::POS_W'(op.position);
	assign full  = (cnt_x >= DEPTH_X);
	assign empty = (cnt_q == '0);

	always_comb begin
		status_d = plsr_pkg::ST_OK;
		op_d     = plsr_pkg::OP_NONE;
		at_d     = '0;
		rd_en    = 1'b0;
		case (plsr_pkg::kind_t'(op.kind))
			plsr_pkg::KIND_PUSH_HEAD: begin
				if (full) begin
					status_d = plsr_pkg::ST_FULL;
				end else begin
					op_d = plsr_pkg::OP_INS;
				end
			end
			plsr_pkg::KIND_PUSH_TAIL: begin
				if (full) begin
					status_d = plsr_pkg::ST_FULL;
				end else begin
					op_d = plsr_pkg::OP_INS;
					at_d = cnt_x;
				end
			end
			plsr_pkg::KIND_INSERT_AT: begin
				if (pos_x > cnt_x) begin
					status_d = plsr_pkg::ST_RANGE;
				end else if (full) begin
					status_d = plsr_pkg::ST_FULL;
				end else begin
					op_d = plsr_pkg::OP_INS;
					at_d = pos_x;
				end
			end
			plsr_pkg::KIND_POP_HEAD: begin
				if (empty) begin
					status_d = plsr_pkg::ST_EMPTY;
				end else begin
					op_d = plsr_pkg::OP_DEL;
				end
			end
			plsr_pkg::KIND_POP_TAIL: begin
				if (empty) begin
					status_d = plsr_pkg::ST_EMPTY;
				end else begin
					op_d = plsr_pkg::OP_DEL;
					at_d = cnt_x - plsr_pkg::POS_W'(1);
				end
			end
			plsr_pkg::KIND_POP_AT: begin
				if (empty) begin
					status_d = plsr_pkg::ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					status_d = plsr_pkg::ST_RANGE;
				end else begin
					op_d = plsr_pkg::OP_DEL;
					at_d = pos_x;
				end
			end
			plsr_pkg::KIND_READ_AT: begin
				if (empty) begin
					status_d = plsr_pkg::ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					status_d = plsr_pkg::ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (op_d)
			plsr_pkg::OP_INS: cnt_d = cnt_q + CW'(1);
			plsr_pkg::OP_DEL: cnt_d = cnt_q - CW'(1);
			default:          cnt_d = cnt_q;
		endcase
	end

	assign adv_out  = v_s1 && (!v_q || res.ready);
	assign op.ready = !v_s1 || adv_out;
	assign accept   = op.valid && op.ready;

	assign cmd.op    = accept ? op_d : plsr_pkg::OP_NONE;
	assign cmd.pos   = at_d;
	assign cmd.value = op.value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [plsr_pkg::DATA_W-1:0] left;
		logic signed [plsr_pkg::DATA_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = cell_data[i];
		end else begin : g_inner_l
			assign left = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = cell_data[i];
		end else begin : g_inner_r
			assign right = cell_data[i+1];
		end

		plsr_cell #(
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.left  (left),
			.right (right),
			.data  (cell_data[i])
		);
	end

	plsr_collect #(
		.DEPTH (DEPTH)
	) u_collect (
		.clk       (clk),
		.load      (accept),
		.rd_en     (rd_en),
		.pos       (pos_x),
		.cell_data (cell_data),
		.value     (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_q   <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_d;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv_out) begin
				v_s1 <= 1'b0;
			end
			if (adv_out) begin
				v_q <= 1'b1;
			end else if (res.ready) begin
				v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= rd_en;
			status_s1 <= status_d;
			count_s1  <= plsr_pkg::CNT_OUT_W'(cnt_d);
		end
		if (adv_out) begin
			value_q  <= rd_s1 ? rd_value : '0;
			status_q <= status_s1;
			count_q  <= count_s1;
		end
	end

	assign res.valid       = v_q;
	assign res.read_value  = value_q;
	assign res.status      = status_q;
	assign res.entry_count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op_d == plsr_pkg::OP_INS |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the list");

	a_refused_stable: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_d != plsr_pkg::ST_OK |=> cnt_q == $past(cnt_q))
		else $error("refused operation changed the count");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_out |=> v_s1)
		else $error("pending result lost while output stalled");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> status_d == plsr_pkg::ST_OK && pos_x < cnt_x)
		else $error("read enabled outside the held entries");

endmodule
